// ===== rtl/sjfk_pkg.sv =====
// shared types, constants and helpers for the six-joint arm pose pipeline
// no dependencies
package sjfk_pkg;

  localparam int AngleBitsDef    = 16;
  localparam int RotFracBitsDef  = 14;
  localparam int TrigStagesDef   = 16;
  localparam int LenBits         = 23;
  localparam int PosBits         = 24;
  localparam int TrigBits        = 34;
  localparam int TableLen        = 24;
  localparam int RegIdxBits      = 3;

  localparam logic signed [TrigBits-1:0] CordicGain = 34'sd652032874;

  localparam logic [RegIdxBits-1:0] REG_D1 = 3'd0;
  localparam logic [RegIdxBits-1:0] REG_A2 = 3'd1;
  localparam logic [RegIdxBits-1:0] REG_A3 = 3'd2;
  localparam logic [RegIdxBits-1:0] REG_D4 = 3'd3;
  localparam logic [RegIdxBits-1:0] REG_D5 = 3'd4;
  localparam logic [RegIdxBits-1:0] REG_D6 = 3'd5;

  localparam logic signed [LenBits-1:0] ResetD1 = 23'sd127300;
  localparam logic signed [LenBits-1:0] ResetA2 = -23'sd612000;
  localparam logic signed [LenBits-1:0] ResetA3 = -23'sd572300;
  localparam logic signed [LenBits-1:0] ResetD4 = 23'sd163941;
  localparam logic signed [LenBits-1:0] ResetD5 = 23'sd115700;
  localparam logic signed [LenBits-1:0] ResetD6 = 23'sd92200;

  // one rotation step of the sine/cosine cell row
  typedef struct packed {
    logic signed [TrigBits-1:0] x;
    logic signed [TrigBits-1:0] y;
    logic signed [TrigBits-1:0] z;
    logic                       flip;
  } cordic_t;

  function automatic logic signed [TrigBits-1:0] arc_at(input int i);
    logic [31:0] v;
    case (i)
      0: v = 32'h20000000;  1: v = 32'h12E4051D;  2: v = 32'h09FB385B;
      3: v = 32'h051111D4;  4: v = 32'h028B0D43;  5: v = 32'h0145D7E1;
      6: v = 32'h00A2F61E;  7: v = 32'h00517C55;  8: v = 32'h0028BE53;
      9: v = 32'h00145F2E; 10: v = 32'h000A2F98; 11: v = 32'h000517CC;
      12: v = 32'h00028BE6; 13: v = 32'h000145F3; 14: v = 32'h0000A2F9;
      15: v = 32'h0000517C; 16: v = 32'h000028BE; 17: v = 32'h0000145F;
      18: v = 32'h00000A2F; 19: v = 32'h00000517; 20: v = 32'h0000028B;
      21: v = 32'h00000145; 22: v = 32'h000000A2; 23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return $signed({2'b00, v});
  endfunction

  // q30 product rounded half up back to q30
  function automatic logic signed [TrigBits-1:0] qmul(input logic signed [TrigBits-1:0] a,
                                                      input logic signed [TrigBits-1:0] b);
    logic signed [2*TrigBits-1:0] p;
    p = 68'(a) * 68'(b) + 68'sd536870912;
    return TrigBits'(p >>> 30);
  endfunction

endpackage

// ===== rtl/sjfk_cordic_cell.sv =====
// one cell of the rotation-mode sine/cosine row
// depends on sjfk_pkg
module sjfk_cordic_cell import sjfk_pkg::*; #(
  parameter int Step = 0
) (
  input  logic    clk,
  input  cordic_t din,
  output cordic_t dout
);
  cordic_t nxt;
  always_comb begin
    nxt = din;
    if (!din.z[TrigBits-1]) begin
      nxt.x = din.x - (din.y >>> Step);
      nxt.y = din.y + (din.x >>> Step);
      nxt.z = din.z - arc_at(Step);
    end else begin
      nxt.x = din.x + (din.y >>> Step);
      nxt.y = din.y - (din.x >>> Step);
      nxt.z = din.z + arc_at(Step);
    end
  end
  always_ff @(posedge clk) begin
    dout <= nxt;
  end
endmodule

// ===== rtl/sjfk_trig.sv =====
// sine and cosine of one binary angle through a row of cordic cells
// depends on sjfk_pkg and sjfk_cordic_cell
module sjfk_trig import sjfk_pkg::*; #(
  parameter int AngleBits  = AngleBitsDef,
  parameter int TrigStages = TrigStagesDef
) (
  input  logic                        clk,
  input  logic        [AngleBits-1:0] angle,
  output logic signed [TrigBits-1:0]  sin_q30,
  output logic signed [TrigBits-1:0]  cos_q30
);
  localparam int Cells = (TrigStages < TableLen) ? TrigStages : TableLen;

  cordic_t chain [0:Cells];
  logic [31:0] t;
  logic [31:0] tf;
  logic        flip;

  always_comb begin
    t    = {angle, {(32-AngleBits){1'b0}}};
    flip = t[31] ^ t[30];
    tf   = flip ? (t + 32'h80000000) : t;
    chain[0].x    = CordicGain;
    chain[0].y    = '0;
    chain[0].z    = TrigBits'($signed(tf));
    chain[0].flip = flip;
  end

  for (genvar i = 0; i < Cells; i++) begin : g_cell
    sjfk_cordic_cell #(.Step(i)) u_cell (.clk(clk), .din(chain[i]), .dout(chain[i+1]));
  end

  always_ff @(posedge clk) begin
    cos_q30 <= chain[Cells].flip ? -chain[Cells].x : chain[Cells].x;
    sin_q30 <= chain[Cells].flip ? -chain[Cells].y : chain[Cells].y;
  end
endmodule

// ===== rtl/six_joint_arm_forward_kinematics.sv =====
// top level: six-joint arm pose from joint angles, config registers, product stages
// depends on sjfk_pkg, sjfk_trig
// Takes one joint vector per clock (start while busy is low; busy never rises, so a
// request is taken every cycle) and returns the tool pose on done. The path runs
// through the cordic cell row (one cell per stage, plus input fold and sign restore)
// followed by four product stages, a position sum stage and the rounding/saturation
// stage. Results are shown for one cycle only; the receiver cannot stall, so it must
// take done when it appears. Link lengths may be changed only while no request is in
// flight.
module six_joint_arm_forward_kinematics import sjfk_pkg::*; #(
  parameter int ANGLE_BITS    = AngleBitsDef,
  parameter int ROT_FRAC_BITS = RotFracBitsDef,
  parameter int TRIG_STAGES   = TrigStagesDef
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  output logic                      done,
  input  logic                      cfg_we,
  input  logic [RegIdxBits-1:0]     cfg_index,
  input  logic [LenBits-1:0]        cfg_data,
  input  logic [ANGLE_BITS-1:0]     joint_base,
  input  logic [ANGLE_BITS-1:0]     joint_shoulder,
  input  logic [ANGLE_BITS-1:0]     joint_elbow,
  input  logic [ANGLE_BITS-1:0]     joint_wrist_one,
  input  logic [ANGLE_BITS-1:0]     joint_wrist_two,
  input  logic [ANGLE_BITS-1:0]     joint_wrist_three,
  output logic [ROT_FRAC_BITS+1:0]  rot_00,
  output logic [ROT_FRAC_BITS+1:0]  rot_01,
  output logic [ROT_FRAC_BITS+1:0]  rot_02,
  output logic [PosBits-1:0]        pos_x,
  output logic [ROT_FRAC_BITS+1:0]  rot_10,
  output logic [ROT_FRAC_BITS+1:0]  rot_11,
  output logic [ROT_FRAC_BITS+1:0]  rot_12,
  output logic [PosBits-1:0]        pos_y,
  output logic [ROT_FRAC_BITS+1:0]  rot_20,
  output logic [ROT_FRAC_BITS+1:0]  rot_21,
  output logic [ROT_FRAC_BITS+1:0]  rot_22,
  output logic [PosBits-1:0]        pos_z
);
  localparam int Cells   = (TRIG_STAGES < TableLen) ? TRIG_STAGES : TableLen;
  localparam int Latency = Cells + 7;
  localparam int RotW    = ROT_FRAC_BITS + 2;
  localparam int SumW    = 62;
  localparam int Sh      = 30 - ROT_FRAC_BITS;
  localparam int RotPreW = TrigBits + 1;

  typedef logic signed [TrigBits-1:0] q_t;

  // link length registers
  logic signed [LenBits-1:0] d1, a2, a3, d4, d5, d6;
  always_ff @(posedge clk) begin
    if (rst) begin
      d1 <= ResetD1; a2 <= ResetA2; a3 <= ResetA3;
      d4 <= ResetD4; d5 <= ResetD5; d6 <= ResetD6;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_D1:  d1 <= cfg_data;
        REG_A2:  a2 <= cfg_data;
        REG_A3:  a3 <= cfg_data;
        REG_D4:  d4 <= cfg_data;
        REG_D5:  d5 <= cfg_data;
        REG_D6:  d6 <= cfg_data;
        default: ;
      endcase
    end
  end

  // request tracking: a valid bit rides alongside the data path
  logic             accept;
  logic [Latency-1:0] vld;
  assign busy   = 1'b0;
  assign accept = start && !busy;
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else     vld <= {vld[Latency-2:0], accept};
  end
  assign done = vld[Latency-1];

  // wrapped joint sum 2+3+4 feeds its own trig row
  logic [ANGLE_BITS-1:0] sum234;
  assign sum234 = joint_shoulder + joint_elbow + joint_wrist_one;

  q_t s1, c1, s2, c2, s3, c3, s5, c5, s6, c6, s234, c234;
  sjfk_trig #(.AngleBits(ANGLE_BITS), .TrigStages(TRIG_STAGES)) u_t1
    (.clk(clk), .angle(joint_base), .sin_q30(s1), .cos_q30(c1));
  sjfk_trig #(.AngleBits(ANGLE_BITS), .TrigStages(TRIG_STAGES)) u_t2
    (.clk(clk), .angle(joint_shoulder), .sin_q30(s2), .cos_q30(c2));
  sjfk_trig #(.AngleBits(ANGLE_BITS), .TrigStages(TRIG_STAGES)) u_t3
    (.clk(clk), .angle(joint_elbow), .sin_q30(s3), .cos_q30(c3));
  sjfk_trig #(.AngleBits(ANGLE_BITS), .TrigStages(TRIG_STAGES)) u_t5
    (.clk(clk), .angle(joint_wrist_two), .sin_q30(s5), .cos_q30(c5));
  sjfk_trig #(.AngleBits(ANGLE_BITS), .TrigStages(TRIG_STAGES)) u_t6
    (.clk(clk), .angle(joint_wrist_three), .sin_q30(s6), .cos_q30(c6));
  sjfk_trig #(.AngleBits(ANGLE_BITS), .TrigStages(TRIG_STAGES)) u_t234
    (.clk(clk), .angle(sum234), .sin_q30(s234), .cos_q30(c234));

  // product stage a: first-level products, one multiplier each
  q_t pa_c2c3, pa_s2s3, pa_s2c3, pa_c2s3, c1c234, s1c234, c1s234, s1s234;
  q_t pa_s1s5, pa_c1s5, s234c5, pa_c5s1, pa_c1c5, pa_s234s5;
  q_t a_s1, a_c1, a_s2, a_c2, a_s5, a_c5, a_s6, a_c6, a_c234;
  always_ff @(posedge clk) begin
    pa_c2c3 <= qmul(c2, c3);  pa_s2s3 <= qmul(s2, s3);
    pa_s2c3 <= qmul(s2, c3);  pa_c2s3 <= qmul(c2, s3);
    c1c234  <= qmul(c1, c234); s1c234 <= qmul(s1, c234);
    c1s234  <= qmul(c1, s234); s1s234 <= qmul(s1, s234);
    pa_s1s5 <= qmul(s1, s5);  pa_c1s5 <= qmul(c1, s5);
    s234c5  <= qmul(s234, c5); pa_c5s1 <= qmul(c5, s1);
    pa_c1c5 <= qmul(c1, c5);  pa_s234s5 <= qmul(s234, s5);
    a_s1 <= s1; a_c1 <= c1; a_s2 <= s2; a_c2 <= c2; a_s5 <= s5; a_c5 <= c5;
    a_s6 <= s6; a_c6 <= c6; a_c234 <= c234;
  end

  // stage b: c23/s23, m0/m1, c1*c2, s1*c2 and the simple rotation entries
  q_t c23, s23, m0, m1, r2, r5, r8;
  q_t b_c1c2, b_s1c2, b_c1s234, b_s1s234, b_s234c5, b_c234, b_s1, b_c1, b_s2;
  q_t b_s6, b_c6;
  always_ff @(posedge clk) begin
    c23 <= pa_c2c3 - pa_s2s3;
    s23 <= pa_s2c3 + pa_c2s3;
    m0  <= pa_s1s5 + qmul(c1c234, a_c5);
    m1  <= qmul(s1c234, a_c5) - pa_c1s5;
    r2  <= pa_c5s1 - qmul(c1c234, a_s5);
    r5  <= -(pa_c1c5 + qmul(s1c234, a_s5));
    r8  <= -pa_s234s5;
    b_c1c2 <= qmul(a_c1, a_c2);
    b_s1c2 <= qmul(a_s1, a_c2);
    b_c1s234 <= c1s234; b_s1s234 <= s1s234; b_s234c5 <= s234c5; b_c234 <= a_c234;
    b_s1 <= a_s1; b_c1 <= a_c1; b_s2 <= a_s2; b_s6 <= a_s6; b_c6 <= a_c6;
  end

  // stage c: remaining rotation entries and c1*c23, s1*c23
  q_t r0, r1, r3, r4, r6, r7, c_r2, c_r5, c_r8, c1c23, s1c23;
  q_t c_c1c2, c_s1c2, c_c1s234, c_s1s234, c_s1, c_c1, c_s2, c_s23, c_c234;
  always_ff @(posedge clk) begin
    r0 <= qmul(b_c6, m0) - qmul(b_s6, b_c1s234);
    r1 <= -qmul(b_c6, b_c1s234) - qmul(b_s6, m0);
    r3 <= qmul(b_c6, m1) - qmul(b_s6, b_s1s234);
    r4 <= -qmul(b_c6, b_s1s234) - qmul(b_s6, m1);
    r6 <= qmul(b_c234, b_s6) + qmul(b_s234c5, b_c6);
    r7 <= qmul(b_c234, b_c6) - qmul(b_s234c5, b_s6);
    c1c23 <= qmul(b_c1, c23);
    s1c23 <= qmul(b_s1, c23);
    c_r2 <= r2; c_r5 <= r5; c_r8 <= r8;
    c_c1c2 <= b_c1c2; c_s1c2 <= b_s1c2; c_c1s234 <= b_c1s234; c_s1s234 <= b_s1s234;
    c_s1 <= b_s1; c_c1 <= b_c1; c_s2 <= b_s2; c_s23 <= s23; c_c234 <= b_c234;
  end

  // stage d: length times term products
  logic signed [SumW-1:0] px_t [5];
  logic signed [SumW-1:0] py_t [5];
  logic signed [SumW-1:0] pz_t [5];
  q_t d_r [9];
  function automatic logic signed [SumW-1:0] lm(input logic signed [LenBits-1:0] l,
                                                input q_t q);
    return SumW'(l) * SumW'(q);
  endfunction
  always_ff @(posedge clk) begin
    px_t[0] <= lm(d6, c_r2);  px_t[1] <= lm(d4, c_s1);  px_t[2] <= lm(a2, c_c1c2);
    px_t[3] <= lm(a3, c1c23); px_t[4] <= lm(d5, c_c1s234);
    py_t[0] <= lm(d6, c_r5);  py_t[1] <= -lm(d4, c_c1); py_t[2] <= lm(a2, c_s1c2);
    py_t[3] <= lm(a3, s1c23); py_t[4] <= lm(d5, c_s1s234);
    pz_t[0] <= SumW'(d1) <<< 30; pz_t[1] <= lm(d6, c_r8); pz_t[2] <= lm(a3, c_s23);
    pz_t[3] <= lm(a2, c_s2);  pz_t[4] <= -lm(d5, c_c234);
    d_r[0] <= r0; d_r[1] <= r1; d_r[2] <= c_r2; d_r[3] <= r3; d_r[4] <= r4;
    d_r[5] <= c_r5; d_r[6] <= r6; d_r[7] <= r7; d_r[8] <= c_r8;
  end

  // stage e: position sums
  logic signed [SumW-1:0] px, py, pz;
  q_t e_r [9];
  always_ff @(posedge clk) begin
    px <= px_t[0] + px_t[1] + px_t[2] + px_t[3] + px_t[4];
    py <= py_t[0] + py_t[1] + py_t[2] + py_t[3] + py_t[4];
    pz <= pz_t[0] + pz_t[1] + pz_t[2] + pz_t[3] + pz_t[4];
    e_r <= d_r;
  end

  // stage f: round and clamp
  function automatic logic [RotW-1:0] rot_fmt(input q_t v);
    logic signed [RotPreW-1:0] w;
    logic signed [RotPreW-1:0] lim;
    w   = RotPreW'(v);
    lim = RotPreW'(1) <<< ROT_FRAC_BITS;
    if (Sh > 0) w = (w + (RotPreW'(1) <<< (Sh > 0 ? Sh - 1 : 0))) >>> Sh;
    if (w > lim)  w = lim;
    if (w < -lim) w = -lim;
    return w[RotW-1:0];
  endfunction
  function automatic logic [PosBits-1:0] pos_fmt(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] w;
    w = (v + SumW'(64'sd536870912)) >>> 30;
    if (w > SumW'(64'sd8388607))  w = SumW'(64'sd8388607);
    if (w < -SumW'(64'sd8388608)) w = -SumW'(64'sd8388608);
    return w[PosBits-1:0];
  endfunction
  always_ff @(posedge clk) begin
    rot_00 <= rot_fmt(e_r[0]); rot_01 <= rot_fmt(e_r[1]); rot_02 <= rot_fmt(e_r[2]);
    rot_10 <= rot_fmt(e_r[3]); rot_11 <= rot_fmt(e_r[4]); rot_12 <= rot_fmt(e_r[5]);
    rot_20 <= rot_fmt(e_r[6]); rot_21 <= rot_fmt(e_r[7]); rot_22 <= rot_fmt(e_r[8]);
    pos_x <= pos_fmt(px); pos_y <= pos_fmt(py); pos_z <= pos_fmt(pz);
  end

  // request in is followed by done after the fixed latency
  a_lat: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##(Latency) done) else $error("done missing after request");
  a_nobusy: assert property (@(posedge clk) !busy) else $error("busy raised");
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(vld[Latency-2])) else $error("done without request");
endmodule
